>>> rtl/drvl_pkg.sv
// Shared types and codes for the run-list VCN-to-LCN resolver.
// No dependencies; used by every module of the block.
`default_nettype none

package drvl_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_MAPPED  = 2'd0,
    ST_SPARSE  = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_LENGTH = 3'b010,
    PH_OFFSET = 3'b100
  } phase_e;

  // Input item: one run-list byte plus list markers
  typedef struct packed {
    logic [7:0]  run_byte;
    logic        first_byte;
    logic        last_byte;
    logic [63:0] target_vcn;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_e     status;
    logic [63:0] lcn;
  } out_item_t;

  // Result handed from the parser to the result queue
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

`default_nettype wire

>>> rtl/drvl_core.sv
// Run-list parser: per-byte state update and result decision in the same cycle.
// Depends on drvl_pkg for item types, phase and status codes.
`default_nettype none

module drvl_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  drvl_pkg::in_item_t  item_i,
  output drvl_pkg::push_t     res_o
);

  // Control state
  drvl_pkg::phase_e phase_q, phase_d;
  logic             fin_q, fin_d;

  // Datapath state
  logic [3:0]  bl_q, bl_d;
  logic [3:0]  idx_q, idx_d;
  logic [3:0]  len_q, len_d;
  logic [3:0]  off_q, off_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] rl_q, rl_d;
  logic [63:0] rv_q, rv_d;
  logic [63:0] rlcn_q, rlcn_d;
  logic [63:0] wanted_q, wanted_d;

  // Effective current state (first byte restarts the list)
  drvl_pkg::phase_e cur_phase;
  logic [63:0] cur_rv, cur_rlcn, cur_wanted;
  logic        active;

  // Shared arithmetic
  logic [63:0] acc_ins, sign_ext, raw_off;
  logic [63:0] close_len, close_lcn, run_end, vcn_diff, mapped_lcn;
  logic [3:0]  idx_inc, bl_dec;
  logic        ge_start, lt_end, is_match, do_close, zero_hdr, emit;

  assign active     = accept_i && (item_i.first_byte || !fin_q);
  assign cur_phase  = item_i.first_byte ? drvl_pkg::PH_HEADER : phase_q;
  assign cur_rv     = item_i.first_byte ? 64'd0 : rv_q;
  assign cur_rlcn   = item_i.first_byte ? 64'd0 : rlcn_q;
  assign cur_wanted = item_i.first_byte ? item_i.target_vcn : wanted_q;

  assign idx_inc = idx_q + 4'd1;
  assign bl_dec  = bl_q - 4'd1;

  // Insert the field byte at its little-endian position; drop bytes past the eighth
  always_comb begin
    acc_ins = acc_q;
    for (int k = 0; k < 8; k++) begin
      if (idx_q == 4'(k)) begin
        acc_ins[8*k +: 8] = acc_q[8*k +: 8] | item_i.run_byte;
      end
    end
  end

  // Sign-extend an offset narrower than eight bytes
  always_comb begin
    sign_ext = 64'd0;
    for (int k = 1; k < 8; k++) begin
      if (off_q == 4'(k) && acc_ins[8*k-1]) begin
        sign_ext = {64{1'b1}} << (8*k);
      end
    end
  end
  assign raw_off = acc_ins | sign_ext;

  // Pick run length and lcn base for the run that closes now
  always_comb begin
    case (cur_phase)
      drvl_pkg::PH_LENGTH: begin
        close_len = acc_ins;
        close_lcn = cur_rlcn;
      end
      drvl_pkg::PH_OFFSET: begin
        close_len = rl_q;
        close_lcn = cur_rlcn + raw_off;
      end
      default: begin
        close_len = 64'd0;
        close_lcn = cur_rlcn;
      end
    endcase
  end

  // Match test against the run window, wrapping modulo 2^64
  assign run_end    = cur_rv + close_len;
  assign ge_start   = cur_wanted >= cur_rv;
  assign lt_end     = cur_wanted < run_end;
  assign is_match   = ge_start && lt_end;
  assign vcn_diff   = cur_wanted - cur_rv;
  assign mapped_lcn = close_lcn + vcn_diff;

  // Next state per phase
  always_comb begin
    phase_d  = cur_phase;
    fin_d    = 1'b0;
    bl_d     = bl_q;
    idx_d    = idx_q;
    len_d    = len_q;
    off_d    = off_q;
    acc_d    = acc_q;
    rl_d     = rl_q;
    rv_d     = cur_rv;
    rlcn_d   = cur_rlcn;
    wanted_d = cur_wanted;
    do_close = 1'b0;
    zero_hdr = 1'b0;
    case (cur_phase)
      drvl_pkg::PH_LENGTH: begin
        acc_d = acc_ins;
        idx_d = idx_inc;
        bl_d  = bl_dec;
        if (bl_dec == 4'd0) begin
          rl_d  = acc_ins;
          acc_d = 64'd0;
          idx_d = 4'd0;
          if (off_q == 4'd0) begin
            do_close = 1'b1;
          end else begin
            phase_d = drvl_pkg::PH_OFFSET;
            bl_d    = off_q;
          end
        end
      end
      drvl_pkg::PH_OFFSET: begin
        acc_d = acc_ins;
        idx_d = idx_inc;
        bl_d  = bl_dec;
        if (bl_dec == 4'd0) begin
          rlcn_d   = close_lcn;
          do_close = 1'b1;
        end
      end
      default: begin
        if (item_i.run_byte == 8'd0) begin
          zero_hdr = 1'b1;
        end else begin
          len_d = item_i.run_byte[3:0];
          off_d = item_i.run_byte[7:4];
          rl_d  = 64'd0;
          acc_d = 64'd0;
          idx_d = 4'd0;
          if (item_i.run_byte[3:0] != 4'd0) begin
            phase_d = drvl_pkg::PH_LENGTH;
            bl_d    = item_i.run_byte[3:0];
          end else if (item_i.run_byte[7:4] != 4'd0) begin
            phase_d = drvl_pkg::PH_OFFSET;
            bl_d    = item_i.run_byte[7:4];
          end else begin
            do_close = 1'b1;
          end
        end
      end
    endcase
    // Close the run: back to header, advance the vcn on a miss
    if (do_close) begin
      phase_d = drvl_pkg::PH_HEADER;
      if (!is_match) begin
        rv_d = run_end;
      end
    end
    fin_d = emit;
  end

  // Result decision: a match wins, else zero header or end of list
  assign emit = zero_hdr || item_i.last_byte || (do_close && is_match);

  always_comb begin
    res_o.valid = active && emit;
    if (do_close && is_match) begin
      if (off_q == 4'd0 && cur_phase != drvl_pkg::PH_HEADER) begin
        res_o.item.status = drvl_pkg::ST_SPARSE;
        res_o.item.lcn    = 64'd0;
      end else if (cur_phase == drvl_pkg::PH_HEADER) begin
        // Header-only run has length zero and cannot match
        res_o.item.status = drvl_pkg::ST_MISSING;
        res_o.item.lcn    = 64'd0;
      end else begin
        res_o.item.status = drvl_pkg::ST_MAPPED;
        res_o.item.lcn    = mapped_lcn;
      end
    end else begin
      res_o.item.status = drvl_pkg::ST_MISSING;
      res_o.item.lcn    = 64'd0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= drvl_pkg::PH_HEADER;
      fin_q   <= 1'b1;
    end else if (active) begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
    end
  end

  // Datapath registers, rewritten on every first byte
  always_ff @(posedge clk_i) begin
    if (active) begin
      bl_q     <= bl_d;
      idx_q    <= idx_d;
      len_q    <= len_d;
      off_q    <= off_d;
      acc_q    <= acc_d;
      rl_q     <= rl_d;
      rv_q     <= rv_d;
      rlcn_q   <= rlcn_d;
      wanted_q <= wanted_d;
    end
  end

  // A result only comes from an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> accept_i)
    else $error("result without accepted item");

  // After a result the list is done until the next first byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> fin_q)
    else $error("list not closed after result");

  // Only a mapped result carries a nonzero lcn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.item.status != drvl_pkg::ST_MAPPED) |-> res_o.item.lcn == 64'd0)
    else $error("nonzero lcn on unmapped result");

endmodule

`default_nettype wire

>>> rtl/drvl_outq.sv
// Two-entry result queue between the parser and the output channel.
// Depends on drvl_pkg for the result item type.
`default_nettype none

module drvl_outq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  drvl_pkg::push_t      push_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output drvl_pkg::out_item_t  out_data_o
);

  drvl_pkg::out_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != 2'd0;
  assign space_o     = cnt_q != 2'd2;
  assign out_data_o  = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    cnt_d = cnt_q;
    if (push_i.valid && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i.valid && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.valid) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Hold result items
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.item;
    end
  end

  // Fill level never exceeds two entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  // No push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> space_o)
    else $error("push into full result queue");

  // Pointers differ exactly when the queue holds one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q != rd_ptr_q) == (cnt_q == 2'd1))
    else $error("result queue pointers inconsistent with count");

endmodule

`default_nettype wire

>>> rtl/data_run_vcn_to_lcn_top.sv
// A result item is registered in the result queue before it appears at the output.
// Throughput: one byte per cycle; the parser updates all running state in that cycle.
// A two-entry result queue keeps bytes flowing while a result waits to be taken;
// input stalls only when both entries are full.
// Reset (rst_ni low, asynchronous) empties the queue and leaves the parser idle,
// ignoring bytes until one arrives with first_byte set.
`default_nettype none

module data_run_vcn_to_lcn_top (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  drvl_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output drvl_pkg::out_item_t  out_data_o
);

  drvl_pkg::push_t res;
  logic            space;
  logic            accept;

  // Accept a byte whenever the result queue has room
  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  drvl_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .res_o    (res)
  );

  drvl_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
